/* src/btda_pkg.sv */
`timescale 1ns / 1ps

package btda_pkg;

  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned CharWidth    = 6;
  localparam int unsigned DefValueWidth = 32;

  localparam logic [CharWidth-1:0] AsciiZero  = 6'd48;
  localparam logic [CharWidth-1:0] AsciiSpace = 6'd32;

  // Bits that actually take part in the conversion.
  function automatic int unsigned eff_width(input int unsigned w);
    return (w < FieldWidth) ? w : FieldWidth;
  endfunction

  // Decimal digits needed for an unsigned number of the given width.
  function automatic int unsigned digit_count(input int unsigned w);
    return (eff_width(w) * 30103) / 100000 + 1;
  endfunction

endpackage

/* src/btda_dabble.sv */
`timescale 1ns / 1ps

module btda_dabble
  import btda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   stall_o,
  input  logic [FieldWidth-1:0]                  value_i,
  output logic                                   res_valid_o,
  input  logic                                   res_take_i,
  output logic [4*digit_count(VALUE_WIDTH)-1:0]  res_bcd_o
);

  localparam int unsigned EffW  = eff_width(VALUE_WIDTH);
  localparam int unsigned NumD  = digit_count(VALUE_WIDTH);
  localparam int unsigned BcdW  = 4 * NumD;
  localparam int unsigned CntW  = $clog2(EffW + 1);

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StHold
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic [EffW-1:0]   bin_q;
  logic [BcdW-1:0]   bcd_q;
  logic [BcdW-1:0]   adj;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NumD; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (valid_i) begin
            cnt_q   <= CntW'(EffW);
            state_q <= StShift;
          end
        end
        StShift: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_q <= StHold;
          end
        end
        StHold: begin
          if (res_take_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && valid_i) begin
      bin_q <= value_i[EffW-1:0];
      bcd_q <= '0;
    end else if (state_q == StShift) begin
      bcd_q <= {adj[BcdW-2:0], bin_q[EffW-1]};
      bin_q <= {bin_q[EffW-2:0], 1'b0};
    end
  end

  assign stall_o     = (state_q != StIdle);
  assign res_valid_o = (state_q == StHold);
  assign res_bcd_o   = bcd_q;

endmodule

/* src/btda_emit.sv */
`timescale 1ns / 1ps

module btda_emit
  import btda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   res_valid_i,
  output logic                                   res_take_o,
  input  logic [4*digit_count(VALUE_WIDTH)-1:0]  res_bcd_i,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output logic [CharWidth-1:0]                   character_o,
  output logic                                   last_o
);

  localparam int unsigned NumD = digit_count(VALUE_WIDTH);
  localparam int unsigned BcdW = 4 * NumD;
  localparam int unsigned LeftW = $clog2(NumD + 1);

  typedef enum logic [1:0] {
    StIdle,
    StSkip,
    StDigit,
    StSpace
  } state_e;

  state_e              state_q;
  logic [LeftW-1:0]    left_q;
  logic [BcdW-1:0]     sr_q;
  logic                valid_q;
  logic [CharWidth-1:0] char_q;
  logic                last_q;
  logic [3:0]          top;
  logic                out_free;
  logic                emit_now;

  assign top      = sr_q[BcdW-1 -: 4];
  assign out_free = !valid_q || !stall_i;
  assign emit_now = (state_q == StDigit || state_q == StSpace) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (emit_now) begin
        valid_q <= 1'b1;
      end else if (!stall_i) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (res_valid_i) begin
            left_q  <= LeftW'(NumD);
            state_q <= StSkip;
          end
        end
        StSkip: begin
          if (top == 4'd0 && left_q > LeftW'(1)) begin
            left_q <= left_q - 1'b1;
          end else begin
            state_q <= StDigit;
          end
        end
        StDigit: begin
          if (out_free) begin
            left_q  <= left_q - 1'b1;
            if (left_q == LeftW'(1)) begin
              state_q <= StSpace;
            end
          end
        end
        StSpace: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && res_valid_i) begin
      sr_q <= res_bcd_i;
    end else if ((state_q == StSkip && top == 4'd0 && left_q > LeftW'(1)) ||
                 (state_q == StDigit && out_free)) begin
      sr_q <= {sr_q[BcdW-5:0], 4'd0};
    end
    if (state_q == StDigit && out_free) begin
      char_q <= AsciiZero + {2'b00, top};
      last_q <= 1'b0;
    end else if (state_q == StSpace && out_free) begin
      char_q <= AsciiSpace;
      last_q <= 1'b1;
    end
  end

  assign res_take_o  = (state_q == StIdle);
  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

/* src/binary_to_decimal_ascii.sv */
// Converts one unsigned number per request into decimal ASCII, one bit per cycle.
// Steps: a serial shift-and-add-three loop over VALUE_WIDTH (at most 32) bits, a
// hand-over to the printer, dropping of leading zeros, then one character per cycle
// while the output is not stalled, ending in a space. A new request is taken once the
// last result has been handed over to the printer; printing overlaps the next conversion.
// Reset (rst_ni, asynchronous, active low) clears all control state.
`timescale 1ns / 1ps

module binary_to_decimal_ascii
  import btda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [FieldWidth-1:0] value_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [CharWidth-1:0]  character_o,
  output logic                  last_o
);

  localparam int unsigned BcdW = 4 * digit_count(VALUE_WIDTH);

  logic            res_valid;
  logic            res_take;
  logic [BcdW-1:0] res_bcd;

  btda_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dabble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .value_i    (value_i),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_bcd_o  (res_bcd)
  );

  btda_emit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_take_o (res_take),
    .res_bcd_i  (res_bcd),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

/* src/btda_checker.sv */
`timescale 1ns / 1ps

module btda_checker
  import btda_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  valid_i,
  input logic                  stall_o,
  input logic                  valid_o,
  input logic                  stall_i,
  input logic [CharWidth-1:0]  character_o,
  input logic                  last_o
);

  // The converter is busy for the cycle after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("request taken without the converter becoming busy");

  // Only a space ends a number, and every other character is a digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o ? (character_o == AsciiSpace)
                        : (character_o >= AsciiZero && character_o <= AsciiZero + 6'd9)))
    else $error("character does not match its last flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output request withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(character_o) && $stable(last_o))
    else $error("stalled output payload changed");

endmodule

bind binary_to_decimal_ascii btda_checker u_btda_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (valid_i),
  .stall_o    (stall_o),
  .valid_o    (valid_o),
  .stall_i    (stall_i),
  .character_o(character_o),
  .last_o     (last_o)
);
